FILE: hw/rtl/quad_code_executor_assert.svh
// Assertion macros used by the checker file of the quad code executor.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef QUAD_CODE_EXECUTOR_ASSERT_SVH
`define QUAD_CODE_EXECUTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define QCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/qce_pkg.sv
// Shared types and constants of the quad code executor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package qce_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned LINE_W    = 9;
  localparam int unsigned OPND_W    = 8;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = 6;

  localparam int unsigned REG_PROGRAM_LENGTH = 0;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_EXEC    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NOP     = 2'd3
  } qce_kind_e;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_ASSIGN  = 4'd4,
    OP_INPUT   = 4'd5,
    OP_PRINT   = 4'd6,
    OP_LESS    = 4'd7,
    OP_GREATER = 4'd8,
    OP_GOTO    = 4'd9,
    OP_GOTOZ   = 4'd10,
    OP_EXIT    = 4'd11
  } qce_op_e;

  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_EXIT    = 3'd1,
    ST_DIV0    = 3'd2,
    ST_BADOP   = 3'd3,
    ST_END     = 3'd4,
    ST_HALTED  = 3'd5
  } qce_status_e;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              x_zero;
    logic              y_zero;
  } qce_alu_res_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } qce_div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } qce_div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/qce_dmem.sv
// Data memory of the quad code executor: one write port, one registered read port.
// Depends on qce_pkg for the word width.
`default_nettype none

module qce_dmem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [qce_pkg::WORD_W-1:0]   wdata_i,
  input  wire logic [AW-1:0]                raddr_i,
  output logic      [qce_pkg::WORD_W-1:0]   rdata_o
);

  logic [qce_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [qce_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/qce_alu.sv
// Combinational arithmetic and compare unit of the quad code executor.
// Depends on qce_pkg for opcodes and the result struct.
`default_nettype none

module qce_alu (
  input  wire qce_pkg::qce_op_e              op_i,
  input  wire logic [qce_pkg::WORD_W-1:0]    x_i,
  input  wire logic [qce_pkg::WORD_W-1:0]    y_i,
  output qce_pkg::qce_alu_res_t              res_o
);

  always_comb begin
    res_o.x_zero = (x_i == '0);
    res_o.y_zero = (y_i == '0);
    case (op_i)
      qce_pkg::OP_ADD: begin
        res_o.value = x_i + y_i;
      end
      qce_pkg::OP_SUB: begin
        res_o.value = x_i - y_i;
      end
      qce_pkg::OP_MUL: begin
        res_o.value = x_i * y_i;
      end
      qce_pkg::OP_LESS: begin
        res_o.value = ($signed(x_i) < $signed(y_i)) ? 32'd1 : 32'd0;
      end
      qce_pkg::OP_GREATER: begin
        res_o.value = ($signed(x_i) > $signed(y_i)) ? 32'd1 : 32'd0;
      end
      default: begin
        res_o.value = x_i;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/qce_div.sv
// Iterative signed divider of the quad code executor, one quotient bit per cycle.
// Truncates toward zero; depends on qce_pkg for widths and the request structs.
`default_nettype none

module qce_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire qce_pkg::qce_div_req_t req_i,
  output qce_pkg::qce_div_rsp_t      rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [qce_pkg::DIV_CNT_W-1:0]       cnt_q, cnt_d;
  logic                                neg_q, neg_d;
  logic [qce_pkg::WORD_W-1:0]          rem_q, rem_d;
  logic [qce_pkg::WORD_W-1:0]          quo_q, quo_d;
  logic [qce_pkg::WORD_W-1:0]          dvs_q, dvs_d;
  logic [qce_pkg::WORD_W:0]            shifted;
  logic [qce_pkg::WORD_W:0]            trial;
  logic                                fits;

  always_comb begin
    shifted = {rem_q, quo_q[qce_pkg::WORD_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = qce_pkg::DIV_CNT_W'(qce_pkg::DIV_STEPS);
      neg_d  = req_i.dividend[qce_pkg::WORD_W-1] ^ req_i.divisor[qce_pkg::WORD_W-1];
      rem_d  = '0;
      quo_d  = req_i.dividend[qce_pkg::WORD_W-1] ? -req_i.dividend : req_i.dividend;
      dvs_d  = req_i.divisor[qce_pkg::WORD_W-1] ? -req_i.divisor : req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? trial[qce_pkg::WORD_W-1:0] : shifted[qce_pkg::WORD_W-1:0];
      quo_d = {quo_q[qce_pkg::WORD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == qce_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -quo_q : quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/quad_code_executor.sv
// Top level of the quad code executor: sequencer, line pointer, output register and APB port.
// Depends on qce_pkg, qce_dmem, qce_alu and qce_div.
`default_nettype none

// Runs one three-address instruction per execute word against a 32-bit data memory that
// reads one address per cycle. After reset the memory is cleared, one word a cycle, and no
// input word is taken during that pass. Load, restart and other non-execute words, and
// execute words that find the block halted or past the program end, give their result
// registered in the cycle after acceptance. An executed instruction reads its two operands
// one after the other from the memory port, in states S_RDX and S_RDY, and registers its
// result at the end of S_RDY; a division goes on to the bit-serial divider in state S_DIV.
// The next input word is accepted once the previous result has been taken.
module quad_code_executor #(
  parameter int unsigned DATA_WORDS    = 256,
  parameter int unsigned PROGRAM_LINES = 256
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [1:0]   kind_i,
  input  wire logic [3:0]   opcode_i,
  input  wire logic [7:0]   first_operand_i,
  input  wire logic [7:0]   second_operand_i,
  input  wire logic [7:0]   dest_address_i,
  input  wire logic signed [31:0] data_value_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [8:0]        next_line_o,
  output logic              print_valid_o,
  output logic signed [31:0] print_value_o,
  output logic [2:0]        status_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AW      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(DATA_WORDS - 1);
  localparam int unsigned PL_CAP  = (PROGRAM_LINES > 511) ? 511 : PROGRAM_LINES;
  localparam logic [qce_pkg::LINE_W-1:0] PL_MAX = qce_pkg::LINE_W'(PL_CAP);
  localparam int unsigned ADDR_CODES = 1 << qce_pkg::OPND_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_RDX   = 5'b00100,
    S_RDY   = 5'b01000,
    S_DIV   = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [AW-1:0]                 clr_cnt_q, clr_cnt_d;
  logic [qce_pkg::LINE_W-1:0]    lp_q, lp_d;
  logic                          halted_q, halted_d;
  logic [qce_pkg::LINE_W-1:0]    plen_q, plen_d;
  logic                          out_valid_q, out_valid_d;
  logic [qce_pkg::LINE_W-1:0]    next_line_q, next_line_d;
  logic                          pvalid_q, pvalid_d;
  logic [qce_pkg::WORD_W-1:0]    pval_q, pval_d;
  qce_pkg::qce_status_e          status_q, status_d;

  qce_pkg::qce_op_e              op_q;
  logic [qce_pkg::OPND_W-1:0]    a1_q, a2_q, dst_q;
  logic [qce_pkg::WORD_W-1:0]    dv_q, x_q;

  logic [AW-1:0]                 addr_mod [ADDR_CODES];
  logic [qce_pkg::LINE_W-1:0]    eff_len;
  logic                          in_accept;
  logic                          cfg_we;

  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [qce_pkg::WORD_W-1:0]    mem_wdata, mem_rdata;

  qce_pkg::qce_alu_res_t         alu_res;
  qce_pkg::qce_div_req_t         div_req;
  qce_pkg::qce_div_rsp_t         div_rsp;

  logic                          res_load;
  qce_pkg::qce_status_e          res_status;
  logic [qce_pkg::LINE_W-1:0]    res_line;
  logic                          res_pvalid;
  logic [qce_pkg::WORD_W-1:0]    res_pval;
  logic                          exec_fin;
  qce_pkg::qce_status_e          exec_status;
  logic [qce_pkg::LINE_W-1:0]    exec_next;
  logic                          exec_pvalid;
  logic [qce_pkg::WORD_W-1:0]    exec_pval;

  for (genvar g = 0; g < ADDR_CODES; g++) begin : g_addr_mod
    localparam logic [AW-1:0] MODV = AW'(g % DATA_WORDS);
    assign addr_mod[g] = MODV;
  end

  assign eff_len    = (plen_q > PL_MAX) ? PL_MAX : plen_q;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite &&
                  (paddr[2] == 1'(qce_pkg::REG_PROGRAM_LENGTH));
  assign plen_d = cfg_we ? pwdata[qce_pkg::LINE_W-1:0] : plen_q;
  assign prdata = (paddr[2] == 1'(qce_pkg::REG_PROGRAM_LENGTH)) ?
                  {{(32 - qce_pkg::LINE_W){1'b0}}, plen_q} : '0;

  qce_dmem #(
    .DEPTH (DATA_WORDS),
    .AW    (AW)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  qce_alu u_alu (
    .op_i  (op_q),
    .x_i   (x_q),
    .y_i   (mem_rdata),
    .res_o (alu_res)
  );

  qce_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d          = state_q;
    clr_cnt_d        = clr_cnt_q;
    lp_d             = lp_q;
    halted_d         = halted_q;
    out_valid_d      = out_valid_q && out_stall_i;
    next_line_d      = next_line_q;
    pvalid_d         = pvalid_q;
    pval_d           = pval_q;
    status_d         = status_q;
    mem_we           = 1'b0;
    mem_waddr        = addr_mod[dst_q];
    mem_wdata        = alu_res.value;
    mem_raddr        = addr_mod[a2_q];
    div_req.start    = 1'b0;
    div_req.dividend = x_q;
    div_req.divisor  = mem_rdata;
    res_load         = 1'b0;
    res_status       = qce_pkg::ST_RUN;
    res_line         = lp_q;
    res_pvalid       = 1'b0;
    res_pval         = '0;
    exec_fin         = 1'b0;
    exec_status      = qce_pkg::ST_RUN;
    exec_next        = lp_q + 1'b1;
    exec_pvalid      = 1'b0;
    exec_pval        = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_WORD) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          case (qce_pkg::qce_kind_e'(kind_i))
            qce_pkg::KIND_LOAD: begin
              mem_we     = 1'b1;
              mem_waddr  = addr_mod[dest_address_i];
              mem_wdata  = data_value_i;
              res_load   = 1'b1;
              res_status = halted_q ? qce_pkg::ST_HALTED : qce_pkg::ST_RUN;
            end
            qce_pkg::KIND_RESTART: begin
              lp_d     = '0;
              halted_d = 1'b0;
              res_load = 1'b1;
              res_line = '0;
            end
            qce_pkg::KIND_EXEC: begin
              if (halted_q) begin
                res_load   = 1'b1;
                res_status = qce_pkg::ST_HALTED;
              end else if (lp_q >= eff_len) begin
                res_load   = 1'b1;
                res_status = qce_pkg::ST_END;
              end else begin
                mem_raddr = addr_mod[first_operand_i];
                state_d   = S_RDX;
              end
            end
            default: begin
              res_load   = 1'b1;
              res_status = halted_q ? qce_pkg::ST_HALTED : qce_pkg::ST_RUN;
            end
          endcase
        end
      end
      S_RDX: begin
        state_d = S_RDY;
      end
      S_RDY: begin
        state_d  = S_IDLE;
        exec_fin = 1'b1;
        case (op_q)
          qce_pkg::OP_ADD, qce_pkg::OP_SUB, qce_pkg::OP_MUL, qce_pkg::OP_ASSIGN,
          qce_pkg::OP_LESS, qce_pkg::OP_GREATER: begin
            mem_we = 1'b1;
          end
          qce_pkg::OP_INPUT: begin
            mem_we    = 1'b1;
            mem_wdata = dv_q;
          end
          qce_pkg::OP_PRINT: begin
            exec_pvalid = 1'b1;
            exec_pval   = x_q;
          end
          qce_pkg::OP_DIV: begin
            if (alu_res.y_zero) begin
              exec_status = qce_pkg::ST_DIV0;
            end else begin
              exec_fin      = 1'b0;
              div_req.start = 1'b1;
              state_d       = S_DIV;
            end
          end
          qce_pkg::OP_GOTO: begin
            exec_next = {1'b0, a1_q};
          end
          qce_pkg::OP_GOTOZ: begin
            if (alu_res.x_zero) begin
              exec_next = {1'b0, a2_q};
            end
          end
          qce_pkg::OP_EXIT: begin
            exec_status = qce_pkg::ST_EXIT;
          end
          default: begin
            exec_status = qce_pkg::ST_BADOP;
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = div_rsp.quotient;
          exec_fin  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (exec_fin) begin
      res_load   = 1'b1;
      res_status = exec_status;
      res_pvalid = exec_pvalid;
      res_pval   = exec_pval;
      if (exec_status == qce_pkg::ST_RUN) begin
        lp_d     = exec_next;
        res_line = exec_next;
        if (exec_next >= eff_len) begin
          res_status = qce_pkg::ST_END;
        end
      end
    end

    if (res_load) begin
      out_valid_d = 1'b1;
      next_line_d = res_line;
      pvalid_d    = res_pvalid;
      pval_d      = res_pval;
      status_d    = res_status;
      if (res_status != qce_pkg::ST_RUN && res_status != qce_pkg::ST_HALTED) begin
        halted_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      lp_q        <= '0;
      halted_q    <= 1'b0;
      plen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      lp_q        <= lp_d;
      halted_q    <= halted_d;
      plen_q      <= plen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_line_q <= next_line_d;
    pvalid_q    <= pvalid_d;
    pval_q      <= pval_d;
    status_q    <= status_d;
    if (in_accept) begin
      op_q  <= qce_pkg::qce_op_e'(opcode_i);
      a1_q  <= first_operand_i;
      a2_q  <= second_operand_i;
      dst_q <= dest_address_i;
      dv_q  <= data_value_i;
    end
    if (state_q == S_RDX) begin
      x_q <= mem_rdata;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_line_o   = next_line_q;
  assign print_valid_o = pvalid_q;
  assign print_value_o = pval_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

FILE: hw/rtl/qce_checker.sv
// Port-level checker of the quad code executor, bound to the top level below.
// Depends on qce_pkg and the macros in quad_code_executor_assert.svh.
`default_nettype none

`include "quad_code_executor_assert.svh"

module qce_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         in_valid_i,
  input wire logic         in_stall_o,
  input wire logic         out_valid_o,
  input wire logic         out_stall_i,
  input wire logic [8:0]   next_line_o,
  input wire logic         print_valid_o,
  input wire logic [31:0]  print_value_o,
  input wire logic [2:0]   status_o
);

  // A stalled result word stays and keeps its payload.
  `QCE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(next_line_o) && $stable(status_o) && $stable(print_value_o) && $stable(print_valid_o),
    "stalled result word changed")

  // The block never takes two words in back-to-back cycles.
  `QCE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
    "input word accepted while the previous one is in flight")

  `QCE_ASSERT_NOW(a_status_code, out_valid_o,
    status_o <= 3'(qce_pkg::ST_HALTED), "result word carries an undefined status")

  // A print only happens on a running step, which may end the program.
  `QCE_ASSERT_NOW(a_print_status, out_valid_o && print_valid_o,
    status_o == 3'(qce_pkg::ST_RUN) || status_o == 3'(qce_pkg::ST_END),
    "print reported with a halting status")

  `QCE_ASSERT_NOW(a_print_zero, out_valid_o && !print_valid_o, print_value_o == '0,
    "print value not zero without a print")

endmodule

bind quad_code_executor qce_checker u_qce_checker (.*);

`default_nettype wire

FILE: test/quad_code_executor_tb.sv
// Self-checking testbench for the quad code executor top level.
// Drives load, execute and restart words, predicts every result in the bench and checks it.
// Depends on qce_pkg and the quad_code_executor RTL.
`timescale 1ns / 1ps

module quad_code_executor_tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 48;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  opcode;
    logic [7:0]  first_operand;
    logic [7:0]  second_operand;
    logic [7:0]  dest_address;
    logic [31:0] data_value;
    bit          fetch;
    int unsigned gap;
  } word_t;

  typedef struct {
    logic [8:0]  next_line;
    logic        print_valid;
    logic [31:0] print_value;
    logic [2:0]  status;
  } step_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [1:0]  kind = '0;
  logic [3:0]  opcode = '0;
  logic [7:0]  first_operand = '0;
  logic [7:0]  second_operand = '0;
  logic [7:0]  dest_address = '0;
  logic [31:0] data_value = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  wire         in_stall;
  wire         out_valid;
  wire  [8:0]  next_line;
  wire         print_valid;
  wire  [31:0] print_value;
  wire  [2:0]  status;
  wire  [31:0] prdata;
  wire         pready;

  logic [31:0] dmem_model [256];
  logic [8:0]  line_ptr = '0;
  logic        halt_flag = 1'b0;
  logic [8:0]  prog_len = '0;
  word_t       program_rom [256];

  word_t        pending_words [$];
  step_result_t expected_steps [$];
  word_t        cur_word;
  int unsigned  hold_cnt = 0;
  int unsigned  stall_left = 0;
  bit           stall_quiet = 1'b0;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;

  quad_code_executor u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .opcode_i         (opcode),
    .first_operand_i  (first_operand),
    .second_operand_i (second_operand),
    .dest_address_i   (dest_address),
    .data_value_i     (data_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .next_line_o      (next_line),
    .print_valid_o    (print_valid),
    .print_value_o    (print_value),
    .status_o         (status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [8:0] active_length();
    return (prog_len > 9'd256) ? 9'd256 : prog_len;
  endfunction

  function automatic step_result_t execute_word(input word_t w);
    step_result_t r;
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  q;
    logic [9:0]   nxt;
    r.next_line   = '0;
    r.print_valid = 1'b0;
    r.print_value = '0;
    r.status      = qce_pkg::ST_RUN;
    case (w.kind)
      qce_pkg::KIND_LOAD: begin
        dmem_model[w.dest_address] = w.data_value;
        r.status = halt_flag ? qce_pkg::ST_HALTED : qce_pkg::ST_RUN;
      end
      qce_pkg::KIND_RESTART: begin
        line_ptr  = '0;
        halt_flag = 1'b0;
      end
      qce_pkg::KIND_EXEC: begin
        if (halt_flag) begin
          r.status = qce_pkg::ST_HALTED;
        end else if (line_ptr >= active_length()) begin
          r.status = qce_pkg::ST_END;
        end else begin
          x   = dmem_model[w.first_operand];
          y   = dmem_model[w.second_operand];
          nxt = {1'b0, line_ptr} + 10'd1;
          case (w.opcode)
            qce_pkg::OP_ADD:    dmem_model[w.dest_address] = x + y;
            qce_pkg::OP_SUB:    dmem_model[w.dest_address] = x - y;
            qce_pkg::OP_MUL:    dmem_model[w.dest_address] = x * y;
            qce_pkg::OP_DIV: begin
              if (y == '0) begin
                r.status = qce_pkg::ST_DIV0;
              end else begin
                if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) q = x;
                else q = $signed(x) / $signed(y);
                dmem_model[w.dest_address] = q;
              end
            end
            qce_pkg::OP_ASSIGN: dmem_model[w.dest_address] = x;
            qce_pkg::OP_INPUT:  dmem_model[w.dest_address] = w.data_value;
            qce_pkg::OP_PRINT: begin
              r.print_valid = 1'b1;
              r.print_value = x;
            end
            qce_pkg::OP_LESS: begin
              dmem_model[w.dest_address] = ($signed(x) < $signed(y)) ? 32'd1 : 32'd0;
            end
            qce_pkg::OP_GREATER: begin
              dmem_model[w.dest_address] = ($signed(x) > $signed(y)) ? 32'd1 : 32'd0;
            end
            qce_pkg::OP_GOTO:  nxt = {2'b00, w.first_operand};
            qce_pkg::OP_GOTOZ: if (x == '0) nxt = {2'b00, w.second_operand};
            qce_pkg::OP_EXIT:  r.status = qce_pkg::ST_EXIT;
            default:           r.status = qce_pkg::ST_BADOP;
          endcase
          if (r.status == qce_pkg::ST_RUN) begin
            line_ptr = nxt[8:0];
            if (line_ptr >= active_length()) r.status = qce_pkg::ST_END;
          end
        end
      end
      default: r.status = halt_flag ? qce_pkg::ST_HALTED : qce_pkg::ST_RUN;
    endcase
    if (r.status != qce_pkg::ST_RUN && r.status != qce_pkg::ST_HALTED) halt_flag = 1'b1;
    r.next_line = line_ptr;
    return r;
  endfunction

  always @(posedge clk_i) begin : driver
    word_t w;
    if (rst_ni) begin
      if (in_valid && !in_stall) expected_steps.push_back(execute_word(cur_word));
      if (!in_valid || !in_stall) begin
        if (hold_cnt != 0) begin
          hold_cnt = hold_cnt - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          if (w.fetch) begin
            w.opcode         = program_rom[line_ptr[7:0]].opcode;
            w.first_operand  = program_rom[line_ptr[7:0]].first_operand;
            w.second_operand = program_rom[line_ptr[7:0]].second_operand;
            w.dest_address   = program_rom[line_ptr[7:0]].dest_address;
          end
          cur_word = w;
          hold_cnt = w.gap;
          in_valid       <= 1'b1;
          kind           <= w.kind;
          opcode         <= w.opcode;
          first_operand  <= w.first_operand;
          second_operand <= w.second_operand;
          dest_address   <= w.dest_address;
          data_value     <= w.data_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    step_result_t exp_r;
    int unsigned  n;
    if (rst_ni) begin
      n = stall_left;
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: line %0d status %0d", next_line, status);
        end else begin
          exp_r = expected_steps.pop_front();
          if (next_line !== exp_r.next_line || print_valid !== exp_r.print_valid ||
              print_value !== exp_r.print_value || status !== exp_r.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected line %0d pv %0b val %h st %0d, got %0d %0b %h %0d",
                       exp_r.next_line, exp_r.print_valid, exp_r.print_value, exp_r.status,
                       next_line, print_valid, print_value, status);
          end
        end
        if ($urandom_range(0, 39) == 0) stall_quiet = !stall_quiet;
        n = stall_quiet ? 0 : $urandom_range(0, 4);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        stall_left = n - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left = 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void push_word(input logic [1:0] k, input logic [3:0] op,
                                    input logic [7:0] a1, input logic [7:0] a2,
                                    input logic [7:0] dst, input logic [31:0] dv,
                                    input bit fetch, input bit quiet);
    word_t w;
    w.kind           = k;
    w.opcode         = op;
    w.first_operand  = a1;
    w.second_operand = a2;
    w.dest_address   = dst;
    w.data_value     = dv;
    w.fetch          = fetch;
    w.gap            = quiet ? 0 : $urandom_range(0, 4);
    pending_words.push_back(w);
  endfunction

  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return $urandom_range(0, 20);
      2:       return -$urandom_range(1, 20);
      3:       return 32'h8000_0000;
      4:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rand_addr();
    return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_target();
    if (active_length() != 0 && $urandom_range(0, 4) != 0)
      return 8'($urandom_range(0, active_length() - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic build_program();
    int unsigned r;
    for (int i = 0; i < 256; i++) begin
      r = $urandom_range(0, 99);
      if (r < 88)
        program_rom[i].opcode = 4'($urandom_range(qce_pkg::OP_ADD, qce_pkg::OP_GOTOZ));
      else if (r < 94) program_rom[i].opcode = qce_pkg::OP_EXIT;
      else program_rom[i].opcode = 4'($urandom_range(12, 15));
      program_rom[i].first_operand  = rand_addr();
      program_rom[i].second_operand = rand_addr();
      program_rom[i].dest_address   = rand_addr();
      if (program_rom[i].opcode == qce_pkg::OP_GOTO) program_rom[i].first_operand = rand_target();
      if (program_rom[i].opcode == qce_pkg::OP_GOTOZ)
        program_rom[i].second_operand = rand_target();
    end
  endtask

  task automatic queue_phase(input int unsigned n_words);
    int unsigned count;
    int unsigned n;
    bit          quiet;
    count = 0;
    while (count < n_words) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(0, 4);
        repeat (n)
          push_word(qce_pkg::KIND_LOAD, 4'd0, 8'd0, 8'd0, rand_addr(), rand_data(), 1'b0, quiet);
        push_word(qce_pkg::KIND_RESTART, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom, 1'b0, quiet);
        count += n + 1;
        n = $urandom_range(1, 30);
        repeat (n)
          push_word(qce_pkg::KIND_EXEC, 4'd0, 8'd0, 8'd0, 8'd0, rand_data(), 1'b1, quiet);
        count += n;
      end else begin
        n = $urandom_range(1, 5);
        repeat (n)
          push_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 8'($urandom),
                    8'($urandom), 8'($urandom), $urandom, 1'b0, quiet);
        count += n;
      end
    end
  endtask

  task automatic write_program_length(input logic [8:0] len);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(qce_pkg::REG_PROGRAM_LENGTH * 4);
    pwdata  <= {23'd0, len};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    prog_len = len;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_steps.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned plen_set [8];
    int unsigned size_set [8];
    for (int i = 0; i < 256; i++) dmem_model[i] = '0;
    plen_set = '{0, 1, 256, 300, 0, 0, 0, 0};
    size_set = '{60, 100, 400, 250, 285, 285, 285, 285};
    for (int i = 4; i < 8; i++) plen_set[i] = $urandom_range(2, 64);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_program_length(9'd256);

    push_word(qce_pkg::KIND_LOAD, 4'd0, 8'd0, 8'd0, 8'd0, 32'h8000_0000, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_LOAD, 4'd0, 8'd0, 8'd0, 8'd255, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_LOAD, 4'd0, 8'd0, 8'd0, 8'd1, 32'h7FFF_FFFF, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_LOAD, 4'd0, 8'd0, 8'd0, 8'd2, 32'd7, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_LOAD, 4'd0, 8'd0, 8'd0, 8'd13, -32'sd17, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_ADD, 8'd1, 8'd2, 8'd3, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_SUB, 8'd0, 8'd2, 8'd4, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_MUL, 8'd1, 8'd1, 8'd5, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_DIV, 8'd0, 8'd255, 8'd6, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_DIV, 8'd13, 8'd2, 8'd7, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_ASSIGN, 8'd3, 8'd0, 8'd8, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_INPUT, 8'd0, 8'd0, 8'd9, -32'sd123, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_PRINT, 8'd6, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_LESS, 8'd0, 8'd1, 8'd10, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_GREATER, 8'd0, 8'd1, 8'd11, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_GOTOZ, 8'd10, 8'd200, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_GOTOZ, 8'd14, 8'd250, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_GOTO, 8'd255, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_ADD, 8'd14, 8'd14, 8'd15, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_PRINT, 8'd1, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_LOAD, 4'd0, 8'd0, 8'd0, 8'd16, 32'd1, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_NOP, 4'd0, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_RESTART, 4'd0, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_DIV, 8'd2, 8'd14, 8'd17, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_RESTART, 4'd0, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, 4'hF, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_RESTART, 4'd0, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_EXEC, qce_pkg::OP_EXIT, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    push_word(qce_pkg::KIND_RESTART, 4'd0, 8'd0, 8'd0, 8'd0, 32'd0, 1'b0, 1'b0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_program_length(9'(plen_set[p]));
      build_program();
      queue_phase(size_set[p]);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_steps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
